FILE: rtl/smm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package smm_pkg;

    localparam int COLOR_W   = 8;
    localparam int DIM_W     = 13;
    localparam int CFG_IDX_W = 3;
    localparam int SUM_W     = 10;

    localparam logic [COLOR_W-1:0] COLOR_MAX   = 8'hFF;
    localparam logic [COLOR_W-1:0] WHITE_LIMIT = 8'd240;
    localparam logic [10:0]        RECIP_3     = 11'd683;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BG_RED       = 3'd0,
        CFG_BG_GREEN     = 3'd1,
        CFG_BG_BLUE      = 3'd2,
        CFG_IMAGE_WIDTH  = 3'd3,
        CFG_IMAGE_HEIGHT = 3'd4,
        CFG_MASK_WIDTH   = 3'd5,
        CFG_MASK_HEIGHT  = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [COLOR_W-1:0] front_red;
        logic [COLOR_W-1:0] front_green;
        logic [COLOR_W-1:0] front_blue;
        logic [COLOR_W-1:0] mask_red;
        logic [COLOR_W-1:0] mask_green;
        logic [COLOR_W-1:0] mask_blue;
    } pix_in_t;

    typedef struct packed {
        logic [COLOR_W-1:0] out_red;
        logic [COLOR_W-1:0] out_green;
        logic [COLOR_W-1:0] out_blue;
        logic [COLOR_W-1:0] out_alpha;
        logic               frame_last;
    } pix_out_t;

    typedef struct packed {
        logic in_mask;
        logic last;
    } pos_info_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } bg_color_t;

    // floor(x / 3) for x up to 765
    function automatic logic [COLOR_W-1:0] div3(input logic [SUM_W-1:0] x);
        logic [20:0] prod;
        prod = 21'(x) * 21'(RECIP_3);
        return prod[18:11];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/smm_pos.sv
`timescale 1ns / 1ps
`default_nettype none

module smm_pos #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        advance,
    input  wire logic [smm_pkg::DIM_W-1:0]   image_width,
    input  wire logic [smm_pkg::DIM_W-1:0]   image_height,
    input  wire logic [smm_pkg::DIM_W-1:0]   mask_width,
    input  wire logic [smm_pkg::DIM_W-1:0]   mask_height,
    output smm_pkg::pos_info_t               info
);
    import smm_pkg::*;

    localparam int CNT_W = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
    localparam int CMP_W = (CNT_W + 1 > DIM_W) ? CNT_W + 1 : DIM_W;

    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic [CMP_W-1:0] w_eff, h_eff;
    logic [CMP_W-1:0] col_inc, row_inc;
    logic             col_wrap, row_wrap;

    function automatic logic [CMP_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(v);
        if (ext == '0)
            return CMP_W'(1);
        else if (ext > CMP_W'(MAX_DIM))
            return CMP_W'(MAX_DIM);
        else
            return ext;
    endfunction

    always_comb
    begin
        w_eff    = clamp_dim(image_width);
        h_eff    = clamp_dim(image_height);
        col_inc  = CMP_W'(col_reg) + CMP_W'(1);
        row_inc  = CMP_W'(row_reg) + CMP_W'(1);
        col_wrap = (col_inc >= w_eff);
        row_wrap = (row_inc >= h_eff);

        info.in_mask = (CMP_W'(col_reg) < CMP_W'(mask_width)) &&
                       (CMP_W'(row_reg) < CMP_W'(mask_height));
        info.last    = col_wrap && row_wrap;

        col_next = col_reg;
        row_next = row_reg;
        if (col_wrap)
        begin
            col_next = '0;
            row_next = row_wrap ? '0 : row_reg + CNT_W'(1);
        end
        else
        begin
            col_next = col_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/smm_calc.sv
`timescale 1ns / 1ps
`default_nettype none

module smm_calc (
    input  wire smm_pkg::pix_in_t    pix,
    input  wire smm_pkg::pos_info_t  pos,
    input  wire smm_pkg::bg_color_t  bg,
    output smm_pkg::pix_out_t        res
);
    import smm_pkg::*;

    logic [COLOR_W-1:0] mr, mg, mb;
    logic [SUM_W-1:0]   mask_sum, front_sum;
    logic [COLOR_W-1:0] alpha_base;
    logic [COLOR_W:0]   alpha_sum;
    logic               all_white;

    always_comb
    begin
        mr = pos.in_mask ? pix.mask_red   : COLOR_MAX;
        mg = pos.in_mask ? pix.mask_green : COLOR_MAX;
        mb = pos.in_mask ? pix.mask_blue  : COLOR_MAX;

        all_white = (mr > WHITE_LIMIT) && (mg > WHITE_LIMIT) && (mb > WHITE_LIMIT);
        mask_sum  = SUM_W'(mr) + SUM_W'(mg) + SUM_W'(mb);
        front_sum = SUM_W'(pix.front_red) + SUM_W'(pix.front_green)
                  + SUM_W'(pix.front_blue);

        alpha_base = all_white ? '0 : COLOR_MAX - div3(mask_sum);
        alpha_sum  = (COLOR_W+1)'(alpha_base) + (COLOR_W+1)'(div3(front_sum));

        res.out_red    = (mr & bg.red)   | pix.front_red;
        res.out_green  = (mg & bg.green) | pix.front_green;
        res.out_blue   = (mb & bg.blue)  | pix.front_blue;
        res.out_alpha  = alpha_sum[COLOR_W] ? COLOR_MAX : alpha_sum[COLOR_W-1:0];
        res.frame_last = pos.last;
    end

endmodule

`default_nettype wire

FILE: rtl/sprite_mask_merge.sv
`timescale 1ns / 1ps
`default_nettype none

// Sprite mask merge: one front pixel plus its aligned mask pixel in, one RGBA pixel out.
// Pixel channel: pix_valid / pix_ready / pix_data, pixels in processing order
//   (rows first to last, columns left to right).
// Result channel: res_valid / res_ready / res_data; frame_last marks the final pixel.
// Config channel: cfg_valid / cfg_ready / cfg_index / cfg_data; cfg_ready is always
//   high, writes take effect at the next edge. Write only while the block is idle.
// Path: a pixel taken into the input register passes through the merge logic into the
//   result register, and so onto res_data, once the result register is free.
// Throughput: one pixel per cycle while res_ready stays high, set by the two-register pipeline
//   (input register, merge logic, result register).
// Reset: both pipeline stages empty, position counters at the first pixel,
//   background black, all sizes 1.
// Stall: when res_ready is low the result register holds and the input register keeps
//   filling; pix_ready drops only once both stages are occupied.
module sprite_mask_merge #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            pix_valid,
    output logic                                 pix_ready,
    input  wire smm_pkg::pix_in_t                pix_data,
    output logic                                 res_valid,
    input  wire logic                            res_ready,
    output smm_pkg::pix_out_t                    res_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [smm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [smm_pkg::DIM_W-1:0]       cfg_data
);
    import smm_pkg::*;

    bg_color_t          bg_reg;
    logic [DIM_W-1:0]   img_w_reg, img_h_reg, mask_w_reg, mask_h_reg;

    pix_in_t            a_pix_reg;
    pos_info_t          a_pos_reg;
    logic               a_valid_reg;
    pix_out_t           b_res_reg;
    logic               b_valid_reg;

    pos_info_t          pos_cur;
    pix_out_t           res_next;
    logic               take_in, adv_b;

    assign cfg_ready = 1'b1;
    assign adv_b     = a_valid_reg && (!b_valid_reg || res_ready);
    assign pix_ready = !a_valid_reg || adv_b;
    assign take_in   = pix_valid && pix_ready;
    assign res_valid = b_valid_reg;
    assign res_data  = b_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_reg     <= '0;
            img_w_reg  <= DIM_W'(1);
            img_h_reg  <= DIM_W'(1);
            mask_w_reg <= DIM_W'(1);
            mask_h_reg <= DIM_W'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_BG_RED:       bg_reg.red   <= cfg_data[COLOR_W-1:0];
                CFG_BG_GREEN:     bg_reg.green <= cfg_data[COLOR_W-1:0];
                CFG_BG_BLUE:      bg_reg.blue  <= cfg_data[COLOR_W-1:0];
                CFG_IMAGE_WIDTH:  img_w_reg    <= cfg_data;
                CFG_IMAGE_HEIGHT: img_h_reg    <= cfg_data;
                CFG_MASK_WIDTH:   mask_w_reg   <= cfg_data;
                CFG_MASK_HEIGHT:  mask_h_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    smm_pos #(
        .MAX_DIM (MAX_DIM)
    ) u_pos (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (take_in),
        .image_width  (img_w_reg),
        .image_height (img_h_reg),
        .mask_width   (mask_w_reg),
        .mask_height  (mask_h_reg),
        .info         (pos_cur)
    );

    smm_calc u_calc (
        .pix (a_pix_reg),
        .pos (a_pos_reg),
        .bg  (bg_reg),
        .res (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (pix_ready)
                a_valid_reg <= pix_valid;
            if (adv_b)
                b_valid_reg <= 1'b1;
            else if (res_ready)
                b_valid_reg <= 1'b0;
        end
    end

    // hold payload until the next transfer into each stage
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            a_pix_reg <= pix_data;
            a_pos_reg <= pos_cur;
        end
        if (adv_b)
            b_res_reg <= res_next;
    end

endmodule

`default_nettype wire

FILE: dv/smm_checker.sv
`timescale 1ns / 1ps

module smm_checker #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            pix_valid,
    input  wire logic                            pix_ready,
    input  smm_pkg::pix_in_t                     pix_data,
    input  wire logic                            res_valid,
    input  wire logic                            res_ready,
    input  smm_pkg::pix_out_t                    res_data,
    input  wire logic                            cfg_valid,
    input  wire logic                            cfg_ready,
    input  wire logic [smm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [smm_pkg::DIM_W-1:0]       cfg_data,
    output int                                   fail_count,
    output int                                   pending
);
    import smm_pkg::*;

    localparam int PRINT_LIMIT = 50;

    logic [COLOR_W-1:0] bg_red;
    logic [COLOR_W-1:0] bg_green;
    logic [COLOR_W-1:0] bg_blue;
    logic [DIM_W-1:0]   image_w;
    logic [DIM_W-1:0]   image_h;
    logic [DIM_W-1:0]   mask_w;
    logic [DIM_W-1:0]   mask_h;
    logic [11:0]        column_pos;
    logic [11:0]        row_pos;
    pix_out_t           merged_q[$];

    task automatic report_mismatch(input string msg);
        if (fail_count < PRINT_LIMIT)
        begin
            $display("[%0t] MISMATCH %s", $realtime, msg);
        end
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [COLOR_W-1:0] got,
                               input logic [COLOR_W-1:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
        end
    endtask

    function automatic int eff_dim(input logic [DIM_W-1:0] v);
        if (v == 0)
        begin
            return 1;
        end
        if (v > MAX_DIM)
        begin
            return MAX_DIM;
        end
        return int'(v);
    endfunction

    // Merge one front/mask pair and advance the raster position.
    task automatic merge_pixel(input pix_in_t p, output pix_out_t r);
        int                 wid;
        int                 hgt;
        int                 mask_sum;
        int                 front_sum;
        int                 alpha;
        logic [COLOR_W-1:0] mr;
        logic [COLOR_W-1:0] mg;
        logic [COLOR_W-1:0] mb;
        wid = eff_dim(image_w);
        hgt = eff_dim(image_h);
        mr = p.mask_red;
        mg = p.mask_green;
        mb = p.mask_blue;
        if (column_pos >= mask_w || row_pos >= mask_h)
        begin
            mr = COLOR_MAX;
            mg = COLOR_MAX;
            mb = COLOR_MAX;
        end
        mask_sum = int'(mr) + int'(mg) + int'(mb);
        front_sum = int'(p.front_red) + int'(p.front_green) + int'(p.front_blue);
        if (mr > WHITE_LIMIT && mg > WHITE_LIMIT && mb > WHITE_LIMIT)
        begin
            alpha = 0;
        end
        else
        begin
            alpha = int'(COLOR_MAX) - mask_sum / 3;
        end
        alpha += front_sum / 3;
        if (alpha > int'(COLOR_MAX))
        begin
            alpha = int'(COLOR_MAX);
        end
        r.out_red = (mr & bg_red) | p.front_red;
        r.out_green = (mg & bg_green) | p.front_green;
        r.out_blue = (mb & bg_blue) | p.front_blue;
        r.out_alpha = alpha[COLOR_W-1:0];
        r.frame_last = 1'b0;
        if (int'(column_pos) + 1 >= wid)
        begin
            column_pos = '0;
            if (int'(row_pos) + 1 >= hgt)
            begin
                row_pos = '0;
                r.frame_last = 1'b1;
            end
            else
            begin
                row_pos++;
            end
        end
        else
        begin
            column_pos++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        pix_out_t predicted;
        pix_out_t want;
        if (!rst_n)
        begin
            bg_red = '0;
            bg_green = '0;
            bg_blue = '0;
            image_w = DIM_W'(1);
            image_h = DIM_W'(1);
            mask_w = DIM_W'(1);
            mask_h = DIM_W'(1);
            column_pos = '0;
            row_pos = '0;
            merged_q.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (pix_valid && pix_ready)
            begin
                merge_pixel(pix_data, predicted);
                merged_q.push_back(predicted);
            end
            if (res_valid && res_ready)
            begin
                if (merged_q.size() == 0)
                begin
                    report_mismatch($sformatf("result with no pixel pending: %h", res_data));
                end
                else
                begin
                    want = merged_q.pop_front();
                    check_field("out_red", res_data.out_red, want.out_red);
                    check_field("out_green", res_data.out_green, want.out_green);
                    check_field("out_blue", res_data.out_blue, want.out_blue);
                    check_field("out_alpha", res_data.out_alpha, want.out_alpha);
                    check_field("frame_last", COLOR_W'(res_data.frame_last),
                                COLOR_W'(want.frame_last));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_BG_RED:       bg_red = cfg_data[COLOR_W-1:0];
                    CFG_BG_GREEN:     bg_green = cfg_data[COLOR_W-1:0];
                    CFG_BG_BLUE:      bg_blue = cfg_data[COLOR_W-1:0];
                    CFG_IMAGE_WIDTH:  image_w = cfg_data;
                    CFG_IMAGE_HEIGHT: image_h = cfg_data;
                    CFG_MASK_WIDTH:   mask_w = cfg_data;
                    CFG_MASK_HEIGHT:  mask_h = cfg_data;
                    default:          ;
                endcase
            end
            pending = merged_q.size();
        end
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import smm_pkg::*;

    localparam int                   WATCHDOG_LIMIT = 2000;
    localparam int                   DRAIN_CYCLES   = 10;
    localparam int                   RANDOM_PHASES  = 12;
    localparam int                   PHASE_ITEMS    = 73;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE      = 3'd7;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 pix_valid = 1'b0;
    logic                 pix_ready;
    pix_in_t              pix_data = '0;
    logic                 res_valid;
    logic                 res_ready = 1'b0;
    pix_out_t             res_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data = '0;
    int                   fail_count;
    int                   pending;
    bit                   pacing = 1'b1;

    always #5 clk = ~clk;

    sprite_mask_merge uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    smm_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready),
        .pix_data   (pix_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    function automatic int pause_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (!pacing || roll < 55)
        begin
            return 0;
        end
        if (roll < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
        begin
            return DIM_W'($urandom_range(1, 6));
        end
        if (roll < 80)
        begin
            return '0;
        end
        if (roll < 88)
        begin
            return DIM_W'($urandom_range(7, 40));
        end
        if (roll < 94)
        begin
            return DIM_W'(4096);
        end
        return DIM_W'($urandom_range(4097, 8191));
    endfunction

    task automatic send_pixel(input logic [COLOR_W-1:0] fr, fg, fb, mr, mg, mb);
        int gap;
        gap = pause_len();
        if (gap > 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_data <= {fr, fg, fb, mr, mg, mb};
        @(posedge clk);
        while (!pix_ready) @(posedge clk);
    endtask

    task automatic send_random_pixel();
        logic [COLOR_W-1:0] f[3];
        logic [COLOR_W-1:0] m[3];
        bit                 bright_mask;
        bit                 bright_front;
        bright_mask = ($urandom_range(0, 2) == 0);
        bright_front = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < 3; i++)
        begin
            f[i] = bright_front ? COLOR_W'($urandom_range(200, 255))
                                : COLOR_W'($urandom_range(0, 255));
            m[i] = bright_mask ? COLOR_W'($urandom_range(232, 255))
                               : COLOR_W'($urandom_range(0, 255));
        end
        send_pixel(f[0], f[1], f[2], m[0], m[1], m[2]);
    endtask

    // Drop valid and hold until every result has drained.
    task automatic wait_idle();
        pix_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic configure(input logic [DIM_W-1:0] red_bg, green_bg, blue_bg,
                             input logic [DIM_W-1:0] img_w, img_h, msk_w, msk_h);
        wait_idle();
        write_reg(CFG_BG_RED, red_bg);
        write_reg(CFG_BG_GREEN, green_bg);
        write_reg(CFG_BG_BLUE, blue_bg);
        write_reg(CFG_IMAGE_WIDTH, img_w);
        write_reg(CFG_IMAGE_HEIGHT, img_h);
        write_reg(CFG_MASK_WIDTH, msk_w);
        write_reg(CFG_MASK_HEIGHT, msk_h);
        if ($urandom_range(0, 3) == 0)
        begin
            write_reg(CFG_SPARE, DIM_W'($urandom_range(0, 8191)));
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : result_sink
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
            end
            else if (res_ready)
            begin
                hold = pause_len();
                if (hold > 0)
                begin
                    res_ready <= 1'b0;
                    hold--;
                end
            end
            else
            begin
                res_ready <= 1'b1;
                hold = $urandom_range(0, 6);
            end
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((pix_valid && pix_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset sizes: every pixel closes a one-pixel frame inside the mask
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd241, 8'd241, 8'd241);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd240, 8'd241, 8'd241);
        send_pixel(8'd10, 8'd20, 8'd30, 8'd241, 8'd255, 8'd240);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd1, 8'd1, 8'd0, 8'd2, 8'd0, 8'd0);

        // mask narrower and shorter than the image
        configure(13'h1FFF, 13'h0AA, 13'h155, 13'd3, 13'd2, 13'd2, 13'd1);
        repeat (6) send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);

        // zero sizes: image acts as 1x1, mask area empty
        configure(13'd255, 13'd255, 13'd255, 13'd0, 13'd0, 13'd0, 13'd0);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'h5A, 8'hA5, 8'h00, 8'h12, 8'h34, 8'h56);
        send_pixel(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0);

        // oversized image and mask, then shrink the image mid-frame
        configure(13'd0, 13'd255, 13'd0, 13'd8191, 13'd4096, 13'd4096, 13'd8191);
        repeat (4) send_pixel(8'd7, 8'd8, 8'd9, 8'd100, 8'd150, 8'd200);
        configure(13'hF0F, 13'h0F0, 13'h1E1, 13'd2, 13'd3, 13'd1, 13'd2);
        repeat (4) send_pixel(8'd3, 8'd60, 8'd90, 8'd0, 8'd128, 8'd255);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            configure(DIM_W'($urandom_range(0, 8191)), DIM_W'($urandom_range(0, 8191)),
                      DIM_W'($urandom_range(0, 8191)),
                      pick_dim(), pick_dim(), pick_dim(), pick_dim());
            pacing = (ph % 4 != 3);
            repeat (PHASE_ITEMS) send_random_pixel();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: sprite_mask_merge.f
rtl/smm_pkg.sv
rtl/smm_pos.sv
rtl/smm_calc.sv
rtl/sprite_mask_merge.sv
dv/smm_checker.sv
dv/tb_top.sv
